FILE: design/qrs_pkg.sv
// Shared types, constants and step functions of the quadratic root solver.
package qrs_pkg;

  localparam int unsigned SQ_STEPS  = 32;  // root bits, two radicand bits per step
  localparam int unsigned DIV_STEPS = 34;  // quotient bits, one per step

  typedef enum logic [1:0] {
    CNT_NONE = 2'd0,
    CNT_ONE  = 2'd1,
    CNT_TWO  = 2'd2,
    CNT_INF  = 2'd3
  } root_cnt_t;

  typedef struct packed {
    logic signed [15:0] a;
    logic signed [15:0] b;
    logic signed [15:0] c;
    root_cnt_t          cnt;
  } side_t;

  typedef struct packed {
    logic [63:0] rad;
    logic [34:0] rem;
    logic [31:0] root;
  } sq_t;

  typedef struct packed {
    logic [33:0] num;
    logic [15:0] rem;
    logic [33:0] quo;
  } dv_t;

  typedef struct packed {
    logic [15:0] md;
    logic        neg1;
    logic        neg2;
    root_cnt_t   cnt;
  } dside_t;

  // One step of the restoring square root: bring in two radicand bits.
  function automatic sq_t sq_step(input sq_t s);
    sq_t         r;
    logic [34:0] t;
    logic [34:0] trial;
    t     = {s.rem[32:0], s.rad[63:62]};
    trial = {1'b0, s.root, 2'b01};
    r.rad = {s.rad[61:0], 2'b00};
    if (t >= trial) begin
      r.rem  = t - trial;
      r.root = {s.root[30:0], 1'b1};
    end else begin
      r.rem  = t;
      r.root = {s.root[30:0], 1'b0};
    end
    return r;
  endfunction

  // One step of the restoring divide: bring in one numerator bit.
  function automatic dv_t dv_step(input dv_t s, input logic [15:0] md);
    dv_t         r;
    logic [16:0] t;
    t     = {s.rem, s.num[33]};
    r.num = {s.num[32:0], 1'b0};
    if (t >= {1'b0, md}) begin
      r.rem = 16'(t - {1'b0, md});
      r.quo = {s.quo[32:0], 1'b1};
    end else begin
      r.rem = t[15:0];
      r.quo = {s.quo[32:0], 1'b0};
    end
    return r;
  endfunction

  // Apply sign and saturate a rounded magnitude to Q16.16.
  function automatic logic [32:0] sat_root(input logic [33:0] q, input logic neg);
    logic [32:0] r;
    if (q == 34'd0) begin
      r = 33'd0;
    end else if (neg) begin
      if (q > 34'h080000000) r = {1'b1, 32'h80000000};
      else                   r = {1'b0, 32'(-q[31:0])};
    end else begin
      if (q > 34'h07FFFFFFF) r = {1'b1, 32'h7FFFFFFF};
      else                   r = {1'b0, q[31:0]};
    end
    return r;
  endfunction

endpackage

FILE: design/quadratic_root_solver_top.sv
// Pipelined quadratic root solver: discriminant, square root and rounded divides.
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+--------------------------
//  input   | in_coef_a, in_coef_b, in_coef_c (Q8.8)  | start high, busy low
//  result  | out_root_count, out_root_first/second,  | out_valid strobe, 1 cycle
//          | out_overflow                            |
//
// An item may enter every cycle; busy stays low since nothing downstream stalls.
// Stages in order: input, multiply and discriminant stages, 32 square root
// stages (two radicand bits each), a numerator stage, 34 divide stages, one output stage.
// Reset clears the valid bits of all stages; data registers are not reset.
module quadratic_root_solver_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] in_coef_a,
  input  logic signed [15:0] in_coef_b,
  input  logic signed [15:0] in_coef_c,
  output logic               out_valid,
  output logic [1:0]         out_root_count,
  output logic signed [31:0] out_root_first,
  output logic signed [31:0] out_root_second,
  output logic               out_overflow
);

  localparam int unsigned SQ = qrs_pkg::SQ_STEPS;
  localparam int unsigned DV = qrs_pkg::DIV_STEPS;

  // input and multiply stages
  logic                      v0_r, v1_r;
  logic signed [15:0]        a0_r, b0_r, c0_r;
  logic signed [15:0]        a1_r, b1_r, c1_r;
  logic signed [31:0]        bb1_r, ac1_r;

  // square root pipeline
  logic                      sq_v_r    [0:SQ];
  qrs_pkg::sq_t              sq_r      [0:SQ];
  qrs_pkg::side_t            sq_side_r [0:SQ];
  qrs_pkg::sq_t              sq_nxt    [0:SQ-1];

  // divide pipeline
  logic                      dv_v_r    [0:DV];
  qrs_pkg::dv_t              dv1_r     [0:DV];
  qrs_pkg::dv_t              dv2_r     [0:DV];
  qrs_pkg::dside_t           dv_side_r [0:DV];
  qrs_pkg::dv_t              dv1_nxt   [0:DV-1];
  qrs_pkg::dv_t              dv2_nxt   [0:DV-1];

  logic signed [34:0]        disc;
  qrs_pkg::root_cnt_t        cnt;
  qrs_pkg::sq_t              sq_init;
  qrs_pkg::side_t            side_init;

  logic signed [34:0]        base, n1, n2;
  logic signed [15:0]        dsr;
  logic [34:0]               mn1, mn2;
  logic [15:0]               md;
  qrs_pkg::dv_t              dv1_init, dv2_init;
  qrs_pkg::dside_t           dside_init;

  logic [32:0]               r1, r2;
  logic [1:0]                cnt_nxt;
  logic [31:0]               first_nxt, second_nxt;
  logic                      ovf_nxt;

  assign busy = 1'b0;

  // discriminant and root count
  always_comb begin
    disc = 35'(bb1_r) - (35'(ac1_r) <<< 2);
    if (a1_r == 16'sd0) begin
      if (b1_r == 16'sd0) cnt = (c1_r == 16'sd0) ? qrs_pkg::CNT_INF : qrs_pkg::CNT_NONE;
      else                cnt = qrs_pkg::CNT_ONE;
    end else if (disc > 35'sd0) begin
      cnt = qrs_pkg::CNT_TWO;
    end else if (disc == 35'sd0) begin
      cnt = qrs_pkg::CNT_ONE;
    end else begin
      cnt = qrs_pkg::CNT_NONE;
    end
    sq_init.rad  = (disc > 35'sd0) ? {disc[33:0], 30'd0} : 64'd0;
    sq_init.rem  = '0;
    sq_init.root = '0;
    side_init.a   = a1_r;
    side_init.b   = b1_r;
    side_init.c   = c1_r;
    side_init.cnt = cnt;
  end

  always_comb begin
    for (int k = 0; k < SQ; k++) begin
      sq_nxt[k] = qrs_pkg::sq_step(sq_r[k]);
    end
  end

  // numerators, divisor magnitude and half-divisor bias for rounding
  always_comb begin
    base = -(35'(sq_side_r[SQ].b) <<< 15);
    if (sq_side_r[SQ].a != 16'sd0) begin
      n1  = base + 35'(sq_r[SQ].root);
      dsr = sq_side_r[SQ].a;
    end else begin
      n1  = -(35'(sq_side_r[SQ].c) <<< 16);
      dsr = sq_side_r[SQ].b;
    end
    n2  = base - 35'(sq_r[SQ].root);
    md  = dsr[15] ? 16'(-dsr) : 16'(dsr);
    mn1 = n1[34] ? 35'(-n1) : 35'(n1);
    mn2 = n2[34] ? 35'(-n2) : 35'(n2);
    dv1_init.num = 34'(mn1 + 35'(md >> 1));
    dv1_init.rem = '0;
    dv1_init.quo = '0;
    dv2_init.num = 34'(mn2 + 35'(md >> 1));
    dv2_init.rem = '0;
    dv2_init.quo = '0;
    dside_init.md   = md;
    dside_init.neg1 = n1[34] ^ dsr[15];
    dside_init.neg2 = n2[34] ^ dsr[15];
    dside_init.cnt  = sq_side_r[SQ].cnt;
  end

  always_comb begin
    for (int k = 0; k < DV; k++) begin
      dv1_nxt[k] = qrs_pkg::dv_step(dv1_r[k], dv_side_r[k].md);
      dv2_nxt[k] = qrs_pkg::dv_step(dv2_r[k], dv_side_r[k].md);
    end
  end

  // saturate and drop unused roots
  always_comb begin
    r1         = qrs_pkg::sat_root(dv1_r[DV].quo, dv_side_r[DV].neg1);
    r2         = qrs_pkg::sat_root(dv2_r[DV].quo, dv_side_r[DV].neg2);
    cnt_nxt    = dv_side_r[DV].cnt;
    first_nxt  = 32'd0;
    second_nxt = 32'd0;
    ovf_nxt    = 1'b0;
    unique case (dv_side_r[DV].cnt)
      qrs_pkg::CNT_TWO: begin
        first_nxt  = r1[31:0];
        second_nxt = r2[31:0];
        ovf_nxt    = r1[32] | r2[32];
      end
      qrs_pkg::CNT_ONE: begin
        first_nxt = r1[31:0];
        ovf_nxt   = r1[32];
      end
      qrs_pkg::CNT_NONE, qrs_pkg::CNT_INF: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r      <= 1'b0;
      v1_r      <= 1'b0;
      out_valid <= 1'b0;
      for (int k = 0; k <= SQ; k++) sq_v_r[k] <= 1'b0;
      for (int k = 0; k <= DV; k++) dv_v_r[k] <= 1'b0;
    end else begin
      v0_r      <= start & ~busy;
      v1_r      <= v0_r;
      sq_v_r[0] <= v1_r;
      for (int k = 0; k < SQ; k++) sq_v_r[k+1] <= sq_v_r[k];
      dv_v_r[0] <= sq_v_r[SQ];
      for (int k = 0; k < DV; k++) dv_v_r[k+1] <= dv_v_r[k];
      out_valid <= dv_v_r[DV];
    end
  end

  always_ff @(posedge clk) begin
    a0_r  <= in_coef_a;
    b0_r  <= in_coef_b;
    c0_r  <= in_coef_c;
    a1_r  <= a0_r;
    b1_r  <= b0_r;
    c1_r  <= c0_r;
    bb1_r <= b0_r * b0_r;
    ac1_r <= a0_r * c0_r;
    sq_r[0]      <= sq_init;
    sq_side_r[0] <= side_init;
    for (int k = 0; k < SQ; k++) begin
      sq_r[k+1]      <= sq_nxt[k];
      sq_side_r[k+1] <= sq_side_r[k];
    end
    dv1_r[0]     <= dv1_init;
    dv2_r[0]     <= dv2_init;
    dv_side_r[0] <= dside_init;
    for (int k = 0; k < DV; k++) begin
      dv1_r[k+1]     <= dv1_nxt[k];
      dv2_r[k+1]     <= dv2_nxt[k];
      dv_side_r[k+1] <= dv_side_r[k];
    end
    out_root_count  <= cnt_nxt;
    out_root_first  <= first_nxt;
    out_root_second <= second_nxt;
    out_overflow    <= ovf_nxt;
  end

endmodule

FILE: dv/tb_quadratic_root_solver_top.sv
// Self-checking testbench for the quadratic root solver: directed table, then random items.
module tb_quadratic_root_solver_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    qrs_pkg::root_cnt_t cnt;
    logic [31:0]        first;
    logic [31:0]        second;
    logic               ovf;
  } roots_t;

  typedef struct {
    logic signed [15:0] a;
    logic signed [15:0] b;
    logic signed [15:0] c;
    bit                 typed;
    roots_t             want;
  } coef_row_t;

  localparam int unsigned N_RANDOM = 1700;
  localparam int unsigned DRAIN    = 80;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic signed [15:0] in_coef_a;
  logic signed [15:0] in_coef_b;
  logic signed [15:0] in_coef_c;
  logic               out_valid;
  logic [1:0]         out_root_count;
  logic signed [31:0] out_root_first;
  logic signed [31:0] out_root_second;
  logic               out_overflow;

  roots_t    roots_pending[$];
  coef_row_t coef_table[$];
  bit        failed;

  quadratic_root_solver_top dut (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400us;
    $display("Test completed with failures");
    $finish;
  end

  function automatic longint unsigned int_sqrt(input longint unsigned x);
    longint unsigned res;
    longint unsigned bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x   = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Round half away from zero, then clamp to Q16.16.
  function automatic logic [31:0] round_div(input longint n, input longint d, inout logic ovf);
    bit              neg;
    longint unsigned mn;
    longint unsigned md;
    longint unsigned q;
    if (d == 0) return 32'd0;
    neg = (n < 0) != (d < 0);
    mn  = n < 0 ? -n : n;
    md  = d < 0 ? -d : d;
    q   = (mn + md / 2) / md;
    if (q == 0) return 32'd0;
    if (neg) begin
      if (q > 64'h80000000) begin
        q   = 64'h80000000;
        ovf = 1'b1;
      end
      return 32'(-q);
    end
    if (q > 64'h7FFFFFFF) begin
      q   = 64'h7FFFFFFF;
      ovf = 1'b1;
    end
    return 32'(q);
  endfunction

  function automatic roots_t solve_roots(input logic signed [15:0] a16,
                                         input logic signed [15:0] b16,
                                         input logic signed [15:0] c16);
    roots_t r;
    longint a, b, c, disc, base, s;
    a = a16;
    b = b16;
    c = c16;
    r.cnt    = qrs_pkg::CNT_NONE;
    r.first  = '0;
    r.second = '0;
    r.ovf    = 1'b0;
    if (a == 0) begin
      if (b == 0) begin
        r.cnt = (c == 0) ? qrs_pkg::CNT_INF : qrs_pkg::CNT_NONE;
      end else begin
        r.cnt   = qrs_pkg::CNT_ONE;
        r.first = round_div(-c * 65536, b, r.ovf);
      end
    end else begin
      disc = b * b - 4 * a * c;
      base = -b * 32768;
      if (disc > 0) begin
        s        = longint'(int_sqrt(longint'(disc) << 30));
        r.cnt    = qrs_pkg::CNT_TWO;
        r.first  = round_div(base + s, a, r.ovf);
        r.second = round_div(base - s, a, r.ovf);
      end else if (disc == 0) begin
        r.cnt   = qrs_pkg::CNT_ONE;
        r.first = round_div(base, a, r.ovf);
      end
    end
    return r;
  endfunction

  function automatic void add_row(input int a, input int b, input int c, input bit typed,
                                  input qrs_pkg::root_cnt_t cnt, input logic [31:0] first,
                                  input logic ovf);
    coef_row_t row;
    row.a           = 16'(a);
    row.b           = 16'(b);
    row.c           = 16'(c);
    row.typed       = typed;
    row.want.cnt    = cnt;
    row.want.first  = first;
    row.want.second = '0;
    row.want.ovf    = ovf;
    coef_table.push_back(row);
  endfunction

  always @(posedge clk) begin
    roots_t w;
    if (rst_n && out_valid) begin
      if (roots_pending.size() == 0) begin
        $error("unexpected result: count %0d", out_root_count);
        failed = 1'b1;
      end else begin
        w = roots_pending.pop_front();
        if (out_root_count !== w.cnt) begin
          $error("root_count: expected %0d, actual %0d", w.cnt, out_root_count);
          failed = 1'b1;
        end
        if (out_root_first !== w.first) begin
          $error("root_first: expected %h, actual %h", w.first, out_root_first);
          failed = 1'b1;
        end
        if (out_root_second !== w.second) begin
          $error("root_second: expected %h, actual %h", w.second, out_root_second);
          failed = 1'b1;
        end
        if (out_overflow !== w.ovf) begin
          $error("overflow: expected %0d, actual %0d", w.ovf, out_overflow);
          failed = 1'b1;
        end
      end
    end
  end

  // Hold start for one item until accepted; leave it high for a zero gap.
  task automatic send_item(input logic signed [15:0] a, input logic signed [15:0] b,
                           input logic signed [15:0] c, input bit typed, input roots_t want);
    int gap;
    gap = $urandom_range(0, 8);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start     <= 1'b1;
    in_coef_a <= a;
    in_coef_b <= b;
    in_coef_c <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    roots_pending.push_back(typed ? want : solve_roots(a, b, c));
  endtask

  initial begin
    roots_t             dummy;
    logic signed [15:0] a, b, c;
    int                 u, v, kind;
    failed    = 1'b0;
    rst_n     = 1'b0;
    start     = 1'b0;
    in_coef_a = '0;
    in_coef_b = '0;
    in_coef_c = '0;
    dummy     = '{qrs_pkg::CNT_NONE, '0, '0, 1'b0};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    add_row(0, 0, 0, 1, qrs_pkg::CNT_INF, 32'd0, 0);
    add_row(0, 0, 1, 1, qrs_pkg::CNT_NONE, 32'd0, 0);
    add_row(0, 0, -32768, 1, qrs_pkg::CNT_NONE, 32'd0, 0);
    add_row(0, 256, -256, 1, qrs_pkg::CNT_ONE, 32'h00010000, 0);
    add_row(0, 1, -32768, 1, qrs_pkg::CNT_ONE, 32'h7FFFFFFF, 1);
    add_row(0, -1, -32768, 1, qrs_pkg::CNT_ONE, 32'h80000000, 0);
    add_row(0, 1, 32767, 1, qrs_pkg::CNT_ONE, 32'(-(32767 * 65536)), 0);
    add_row(256, 0, 256, 1, qrs_pkg::CNT_NONE, 32'd0, 0);
    add_row(-32768, 0, -32768, 1, qrs_pkg::CNT_NONE, 32'd0, 0);
    add_row(256, -512, 256, 1, qrs_pkg::CNT_ONE, 32'h00010000, 0);
    add_row(0, 32767, 32767, 0, qrs_pkg::CNT_NONE, 0, 0);
    add_row(0, -32768, 32767, 0, qrs_pkg::CNT_NONE, 0, 0);
    add_row(256, 0, -256, 0, qrs_pkg::CNT_NONE, 0, 0);
    add_row(1, 32767, 0, 0, qrs_pkg::CNT_NONE, 0, 0);
    add_row(1, -32768, -32768, 0, qrs_pkg::CNT_NONE, 0, 0);
    add_row(-1, 32767, 32767, 0, qrs_pkg::CNT_NONE, 0, 0);
    add_row(32767, 32767, -32768, 0, qrs_pkg::CNT_NONE, 0, 0);
    add_row(-32768, -32768, 32767, 0, qrs_pkg::CNT_NONE, 0, 0);
    add_row(-32768, -32768, -32768, 0, qrs_pkg::CNT_NONE, 0, 0);
    add_row(32767, 1, 0, 0, qrs_pkg::CNT_NONE, 0, 0);
    add_row(1, 2, 1, 0, qrs_pkg::CNT_NONE, 0, 0);
    add_row(-1, 0, 32767, 0, qrs_pkg::CNT_NONE, 0, 0);

    foreach (coef_table[i])
      send_item(coef_table[i].a, coef_table[i].b, coef_table[i].c,
                coef_table[i].typed, coef_table[i].want);

    for (int n = 0; n < N_RANDOM; n++) begin
      a    = 16'($urandom);
      b    = 16'($urandom);
      c    = 16'($urandom);
      kind = $urandom_range(0, 15);
      if (kind < 2) begin
        a = '0;
      end else if (kind == 2) begin
        a = '0;
        b = '0;
        if ($urandom_range(0, 1)) c = '0;
      end else if (kind < 5) begin
        // perfect square: double root
        u = $signed($urandom_range(0, 254)) - 127;
        v = $signed($urandom_range(0, 254)) - 127;
        if (u == 0) u = 1;
        a = 16'(u * u * ((kind == 3) ? 1 : -1));
        c = 16'(v * v * ((kind == 3) ? 1 : -1));
        b = 16'(2 * u * v);
      end else if (kind < 9) begin
        a = 16'($signed($urandom_range(0, 1023)) - 512);
        b = 16'($signed($urandom_range(0, 4095)) - 2048);
        c = 16'($signed($urandom_range(0, 1023)) - 512);
      end
      send_item(a, b, c, 0, dummy);
    end
    start <= 1'b0;

    while (roots_pending.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (!failed) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
